[rtl/assert_macros.svh]
// Assertion macros used by the RTL.
// Stand-alone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/esc_pkg.sv]
// Types and constants for the expression syntax checker.
// No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

   // error codes reported on rsp_error_code
   typedef enum logic [3:0] {
      ERR_NONE       = 4'd0,
      ERR_EMPTY      = 4'd1,
      ERR_LEAD_OP    = 4'd2,
      ERR_BAD_CHAR   = 4'd3,
      ERR_EXTRA_CLOSE = 4'd4,
      ERR_BANG       = 4'd5,
      ERR_PERCENT    = 4'd6,
      ERR_COMMA      = 4'd7,
      ERR_OPEN_PAREN = 4'd8,
      ERR_TRAIL_OP   = 4'd9,
      ERR_DEPTH      = 4'd10
   } err_type;

   localparam int POS_W = 16;
   localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LO_A   = 8'h61;
   localparam logic [7:0] CH_LO_Z   = 8'h7A;

endpackage

[rtl/expression_syntax_checker_unit.sv]
// Expression syntax checker: consumes one character word per cycle while
// req_ready is high and reports the verdict when the end word arrives.
//
// Channels: req_* carries a character word (req_character) or an end word
// (req_end_of_expression = 1). rsp_* carries one verdict per end word:
// valid flag, first error code and its position.
// Throughput: one word per cycle while req_ready is high. The check state
// (depth, last non-space character, index, first error) is updated in the
// cycle the word is accepted; the verdict appears in the result register in
// the cycle after the end word is accepted. Character words produce no result.
// Stall: while a verdict waits on rsp_ready low, req_ready drops, so at
// most one verdict is held; req_ready returns in the cycle it is taken.
// Reset clears the check state and drops rsp_valid; the block accepts
// words from the first cycle after reset. After each end word the check
// state is cleared for the next expression.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module expression_syntax_checker_unit #(
   parameter int DEPTH_BITS = 16,
   parameter int INDEX_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_character,
   input  logic                      req_end_of_expression,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_valid_res,
   output logic [3:0]                rsp_error_code,
   output logic [esc_pkg::POS_W-1:0] rsp_error_position
);
   import esc_pkg::*;

   localparam int WideW = (INDEX_BITS > POS_W) ? INDEX_BITS : POS_W;

   logic [DEPTH_BITS-1:0] paren_depth_ff, paren_depth_in;
   logic [7:0]            last_nonspace_ff, last_nonspace_in;
   logic [INDEX_BITS-1:0] char_index_ff, char_index_in;
   err_type               first_error_ff, first_error_in;
   logic [POS_W-1:0]      first_error_pos_ff, first_error_pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_valid_res_ff, rsp_valid_res_in;
   err_type               rsp_error_code_ff, rsp_error_code_in;
   logic [POS_W-1:0]      rsp_error_position_ff, rsp_error_position_in;

   logic                  accept;
   logic [7:0]            c;
   logic [WideW-1:0]      idx_wide;
   logic [POS_W-1:0]      idx_sat;
   logic                  after_operand;
   logic                  is_allowed;
   logic                  lead_op;
   logic                  trail_op;
   err_type               char_err;
   err_type               end_code;
   logic [POS_W-1:0]      end_pos;

   logic                  end_accept;
   logic                  err_accept;
   logic                  end_done;
   logic                  flag_agrees;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign c         = req_character;

   // position of the current word, clamped to the 16-bit field
   assign idx_wide = WideW'(char_index_ff);
   assign idx_sat  = (idx_wide > WideW'(POS_MAX)) ? POS_MAX : idx_wide[POS_W-1:0];

   assign after_operand = (last_nonspace_ff inside {[CH_ZERO:CH_NINE]}) ||
                          (last_nonspace_ff == CH_RPAREN);
   assign is_allowed = (c inside {[CH_ZERO:CH_NINE], [CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z],
                                  CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET,
                                  CH_LPAREN, CH_RPAREN, CH_DOT, CH_BANG, CH_PCT,
                                  CH_COMMA, CH_SPACE});
   // minus may open an expression, the others may not
   assign lead_op = (char_index_ff == '0) &&
                    (c inside {CH_PLUS, CH_STAR, CH_SLASH, CH_CARET, CH_PCT});
   assign trail_op = (last_nonspace_ff == CH_NUL) ||
                     (last_nonspace_ff inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                               CH_CARET, CH_PCT, CH_COMMA});

   always_comb begin
      char_err = ERR_NONE;
      if (lead_op) begin
         char_err = ERR_LEAD_OP;
      end else if (c != CH_SPACE) begin
         if (!is_allowed) begin
            char_err = ERR_BAD_CHAR;
         end else begin
            case (c)
               CH_LPAREN: if (&paren_depth_ff)     char_err = ERR_DEPTH;
               CH_RPAREN: if (paren_depth_ff == '0) char_err = ERR_EXTRA_CLOSE;
               CH_BANG:   if (!after_operand)      char_err = ERR_BANG;
               CH_PCT:    if (!after_operand)      char_err = ERR_PERCENT;
               CH_COMMA:  if (!after_operand)      char_err = ERR_COMMA;
               default:   char_err = ERR_NONE;
            endcase
         end
      end
   end

   always_comb begin
      if (first_error_ff != ERR_NONE) begin
         end_code = first_error_ff;
         end_pos  = first_error_pos_ff;
      end else if (char_index_ff == '0) begin
         end_code = ERR_EMPTY;
         end_pos  = '0;
      end else if (paren_depth_ff != '0) begin
         end_code = ERR_OPEN_PAREN;
         end_pos  = idx_sat;
      end else if (trail_op) begin
         end_code = ERR_TRAIL_OP;
         end_pos  = idx_sat;
      end else begin
         end_code = ERR_NONE;
         end_pos  = '0;
      end
   end

   always_comb begin
      paren_depth_in        = paren_depth_ff;
      last_nonspace_in      = last_nonspace_ff;
      char_index_in         = char_index_ff;
      first_error_in        = first_error_ff;
      first_error_pos_in    = first_error_pos_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      rsp_valid_res_in      = rsp_valid_res_ff;
      rsp_error_code_in     = rsp_error_code_ff;
      rsp_error_position_in = rsp_error_position_ff;
      if (accept) begin
         if (req_end_of_expression) begin
            rsp_valid_in          = 1'b1;
            rsp_valid_res_in      = (end_code == ERR_NONE);
            rsp_error_code_in     = end_code;
            rsp_error_position_in = end_pos;
            paren_depth_in        = '0;
            last_nonspace_in      = CH_NUL;
            char_index_in         = '0;
            first_error_in        = ERR_NONE;
            first_error_pos_in    = '0;
         end else begin
            if (first_error_ff == ERR_NONE) begin
               if (char_err != ERR_NONE) begin
                  first_error_in     = char_err;
                  first_error_pos_in = idx_sat;
               end else if (c != CH_SPACE) begin
                  last_nonspace_in = c;
                  if (c == CH_LPAREN) begin
                     paren_depth_in = paren_depth_ff + DEPTH_BITS'(1);
                  end else if (c == CH_RPAREN) begin
                     paren_depth_in = paren_depth_ff - DEPTH_BITS'(1);
                  end
               end
            end
            if (!(&char_index_ff)) begin
               char_index_in = char_index_ff + INDEX_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paren_depth_ff     <= '0;
         last_nonspace_ff   <= CH_NUL;
         char_index_ff      <= '0;
         first_error_ff     <= ERR_NONE;
         first_error_pos_ff <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         paren_depth_ff     <= paren_depth_in;
         last_nonspace_ff   <= last_nonspace_in;
         char_index_ff      <= char_index_in;
         first_error_ff     <= first_error_in;
         first_error_pos_ff <= first_error_pos_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_res_ff      <= rsp_valid_res_in;
      rsp_error_code_ff     <= rsp_error_code_in;
      rsp_error_position_ff <= rsp_error_position_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_res      = rsp_valid_res_ff;
   assign rsp_error_code     = rsp_error_code_ff;
   assign rsp_error_position = rsp_error_position_ff;

   assign end_accept  = accept && req_end_of_expression;
   assign err_accept  = accept && !req_end_of_expression && (first_error_ff != ERR_NONE);
   assign end_done    = rsp_valid_ff && (char_index_ff == '0) && (paren_depth_ff == '0) &&
                        (first_error_ff == ERR_NONE);
   assign flag_agrees = rsp_valid_res_ff == (rsp_error_code_ff == ERR_NONE);

   `ASSERT_NEXT(a_end_gives_rsp, clock, reset, end_accept, end_done, "end word not closed")
   `ASSERT_NEXT(a_error_sticky, clock, reset, err_accept, $stable(first_error_ff), "err moved")
   `ASSERT_NEXT(a_last_held, clock, reset, err_accept, $stable(last_nonspace_ff), "char moved")
   `ASSERT_SAME(a_verdict_flag, clock, reset, rsp_valid_ff, flag_agrees, "flag vs code")

endmodule
